FILE: src/rsd_pkg.sv
package rsd_pkg;

    localparam int DEPTH_DEF  = 64;
    localparam int DATA_W     = 32;
    localparam int MAG_W      = 31;
    // digits are taken four bits at a time: a stable magnitude sort in base 16
    localparam int DIGIT_W    = 4;
    localparam int NUM_DIGITS = 16;
    localparam int PASS_W     = 4;

    typedef enum logic [4:0] {
        ST_LOAD    = 5'b00001,
        ST_COUNT   = 5'b00010,
        ST_PREFIX  = 5'b00100,
        ST_SCATTER = 5'b01000,
        ST_EMIT    = 5'b10000
    } state_t;

    function automatic logic [MAG_W-1:0] mag_of(input logic [DATA_W-1:0] v);
        logic [MAG_W-1:0] m;
        m = v[DATA_W-1] ? (~v[MAG_W-1:0] + MAG_W'(1)) : v[MAG_W-1:0];
        return m;
    endfunction

endpackage

FILE: src/rsd_ram.sv
module rsd_ram #(
    parameter int AW = 6,
    parameter int DW = 32
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [2**AW];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/radix_sort_decimal_lsd_core.sv
// operation: a set of n values is loaded, then each digit pass runs a count walk, a
// prefix over the 16 bins and a scatter walk, then the set is emitted
// (both sign walks read every entry)
// passes: one per hex digit of the largest magnitude (at most 8); each pass walks
// the element memory twice through its single registered read port
// reset: synchronous active-low aresetn clears control, counts and output valid
module radix_sort_decimal_lsd_core #(
    parameter int DEPTH = rsd_pkg::DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // value
    input  logic        s_tlast,  // last_item
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // sorted_value
    output logic        m_tlast,  // end_of_set
    output logic        m_tuser   // truncated
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int DW = rsd_pkg::DATA_W;
    localparam int MW = rsd_pkg::MAG_W;
    localparam int NB = rsd_pkg::NUM_DIGITS;
    localparam int GW = rsd_pkg::DIGIT_W;
    localparam int PW = rsd_pkg::PASS_W;

    rsd_pkg::state_t state_reg, state_next;

    logic [CW-1:0] count_reg, count_next;     // elements stored
    logic [MW-1:0] largest_reg, largest_next;
    logic          ovf_reg, ovf_next;
    logic          cur_reg, cur_next;         // which memory holds the live order
    logic [PW-1:0] pass_reg, pass_next;
    logic [CW-1:0] idx_reg, idx_next;         // walk index
    logic          pend_reg, pend_next;       // a read is in flight
    logic          neg_phase_reg, neg_phase_next;
    logic [CW-1:0] emitted_reg, emitted_next;
    logic [CW-1:0] acc_reg, acc_next;         // running prefix sum
    logic [CW-1:0] bin_reg [NB];              // counts, then write offsets
    logic [CW-1:0] bin_next [NB];

    logic          out_valid_reg, out_valid_next;
    logic [DW-1:0] out_data_reg, out_data_next;
    logic          out_last_reg, out_last_next;
    logic          out_user_reg, out_user_next;

    // memory ports
    logic          wr_en;
    logic          wr_sel;
    logic [AW-1:0] wr_addr;
    logic [DW-1:0] wr_data;
    logic [AW-1:0] rd_addr;
    logic [DW-1:0] rdata0, rdata1, rdata;

    logic          in_req;
    logic [DW-1:0] in_val;
    logic [MW-1:0] in_mag;
    logic [MW-1:0] rd_mag;
    logic [MW-1:0] rd_shift;
    logic [GW-1:0] rd_digit;
    logic [5:0]    shamt;
    logic [5:0]    shamt_nxt;
    logic [MW-1:0] largest_shift;
    logic          issue;

    rsd_ram #(.AW(AW), .DW(DW)) u_ram0 (
        .aclk  (aclk),
        .we    (wr_en && !wr_sel),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rdata0)
    );

    rsd_ram #(.AW(AW), .DW(DW)) u_ram1 (
        .aclk  (aclk),
        .we    (wr_en && wr_sel),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rdata1)
    );

    assign rdata    = cur_reg ? rdata1 : rdata0;
    assign s_tready = (state_reg == rsd_pkg::ST_LOAD);
    assign in_req   = s_tvalid && s_tready;

    // the most negative pattern saturates to -(2^31-1)
    assign in_val   = (s_tdata == {1'b1, {(DW-1){1'b0}}}) ? {1'b1, {(DW-2){1'b0}}, 1'b1}
                                                          : s_tdata;
    assign in_mag   = rsd_pkg::mag_of(in_val);
    assign rd_mag   = rsd_pkg::mag_of(rdata);
    assign shamt    = {pass_reg[3:0], 2'b00};
    assign rd_shift = rd_mag >> shamt;
    assign rd_digit = rd_shift[GW-1:0];
    // digit place of the following pass
    assign shamt_nxt = {pass_reg[3:0] + 4'd1, 2'b00};
    assign largest_shift = largest_reg >> shamt_nxt;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_user_reg;

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        largest_next   = largest_reg;
        ovf_next       = ovf_reg;
        cur_next       = cur_reg;
        pass_next      = pass_reg;
        idx_next       = idx_reg;
        pend_next      = 1'b0;
        neg_phase_next = neg_phase_reg;
        emitted_next   = emitted_reg;
        acc_next       = acc_reg;
        bin_next       = bin_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_user_next  = out_user_reg;
        wr_en          = 1'b0;
        wr_sel         = cur_reg;
        wr_addr        = count_reg[AW-1:0];
        wr_data        = in_val;
        rd_addr        = idx_reg[AW-1:0];
        issue          = 1'b0;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            rsd_pkg::ST_LOAD: begin
                if (in_req) begin
                    if (count_reg < CW'(DEPTH)) begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CW'(1);
                        if (in_mag > largest_reg) begin
                            largest_next = in_mag;
                        end
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_tlast) begin
                        idx_next  = '0;
                        pass_next = '0;
                        for (int j = 0; j < NB; j++) begin
                            bin_next[j] = '0;
                        end
                        // no digit passes when every magnitude is zero
                        if ((count_reg < CW'(DEPTH) ? ((in_mag > largest_reg) ? in_mag
                                : largest_reg) : largest_reg) == '0) begin
                            neg_phase_next = 1'b1;
                            emitted_next   = '0;
                            state_next     = rsd_pkg::ST_EMIT;
                        end else begin
                            state_next = rsd_pkg::ST_COUNT;
                        end
                    end
                end
            end

            rsd_pkg::ST_COUNT: begin
                if (idx_reg < count_reg) begin
                    idx_next  = idx_reg + CW'(1);
                    pend_next = 1'b1;
                end
                if (pend_reg) begin
                    bin_next[rd_digit] = bin_reg[rd_digit] + CW'(1);
                end
                if (idx_reg == count_reg && !pend_reg) begin
                    idx_next   = '0;
                    acc_next   = '0;
                    state_next = rsd_pkg::ST_PREFIX;
                end
            end

            rsd_pkg::ST_PREFIX: begin
                // turn counts into exclusive start offsets, one bin a cycle
                bin_next[idx_reg[GW-1:0]] = acc_reg;
                acc_next = acc_reg + bin_reg[idx_reg[GW-1:0]];
                idx_next = idx_reg + CW'(1);
                if (idx_reg[GW-1:0] == GW'(NB - 1)) begin
                    idx_next   = '0;
                    state_next = rsd_pkg::ST_SCATTER;
                end
            end

            rsd_pkg::ST_SCATTER: begin
                if (idx_reg < count_reg) begin
                    idx_next  = idx_reg + CW'(1);
                    pend_next = 1'b1;
                end
                if (pend_reg) begin
                    wr_en              = 1'b1;
                    wr_sel             = !cur_reg;
                    wr_addr            = bin_reg[rd_digit][AW-1:0];
                    wr_data            = rdata;
                    bin_next[rd_digit] = bin_reg[rd_digit] + CW'(1);
                end
                if (idx_reg == count_reg && !pend_reg) begin
                    cur_next  = !cur_reg;
                    pass_next = pass_reg + PW'(1);
                    idx_next  = '0;
                    for (int j = 0; j < NB; j++) begin
                        bin_next[j] = '0;
                    end
                    if (largest_shift == '0 || pass_reg == PW'(7)) begin
                        neg_phase_next = 1'b1;
                        emitted_next   = '0;
                        state_next     = rsd_pkg::ST_EMIT;
                    end else begin
                        state_next = rsd_pkg::ST_COUNT;
                    end
                end
            end

            rsd_pkg::ST_EMIT: begin
                // negatives from the top down, then non-negatives from the bottom up
                rd_addr = neg_phase_reg ? (count_reg[AW-1:0] - AW'(1) - idx_reg[AW-1:0])
                                        : idx_reg[AW-1:0];
                issue   = !pend_reg && !out_valid_reg && (idx_reg < count_reg);
                if (issue) begin
                    idx_next  = idx_reg + CW'(1);
                    pend_next = 1'b1;
                end
                if (pend_reg && (rdata[DW-1] == neg_phase_reg)) begin
                    out_valid_next = 1'b1;
                    out_data_next  = rdata;
                    out_last_next  = (emitted_reg + CW'(1) == count_reg);
                    out_user_next  = ovf_reg;
                    emitted_next   = emitted_reg + CW'(1);
                end
                if (idx_reg == count_reg && !pend_reg) begin
                    idx_next = '0;
                    if (neg_phase_reg) begin
                        neg_phase_next = 1'b0;
                    end else begin
                        count_next   = '0;
                        largest_next = '0;
                        ovf_next     = 1'b0;
                        state_next   = rsd_pkg::ST_LOAD;
                    end
                end
            end

            default: begin
                state_next = rsd_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= rsd_pkg::ST_LOAD;
            count_reg     <= '0;
            largest_reg   <= '0;
            ovf_reg       <= 1'b0;
            cur_reg       <= 1'b0;
            pass_reg      <= '0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            neg_phase_reg <= 1'b0;
            emitted_reg   <= '0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int j = 0; j < NB; j++) begin
                bin_reg[j] <= '0;
            end
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            largest_reg   <= largest_next;
            ovf_reg       <= ovf_next;
            cur_reg       <= cur_next;
            pass_reg      <= pass_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            neg_phase_reg <= neg_phase_next;
            emitted_reg   <= emitted_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
            bin_reg       <= bin_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        out_user_reg <= out_user_next;
    end

endmodule

FILE: src/rsd_checker.sv
module rsd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast
);

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // no new request is taken while a set is still being emitted
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input open during emission");

    // loading closes only after a last request
    assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_tready) |-> $past(s_tvalid && s_tlast))
        else $error("load closed without last");

    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind radix_sort_decimal_lsd_core rsd_checker u_rsd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

FILE: dv/radix_sort_checker.sv
module radix_sort_checker #(
    parameter int DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic        m_tlast,
    input  logic        m_tuser,
    output int          fail_count,
    output int          pending,
    output int          sets_sorted
);

    typedef struct packed {
        logic [31:0] value;
        logic        eos;
        logic        trunc;
    } sorted_t;

    sorted_t     sorted_q[$];
    logic [31:0] held[$];
    logic        dropped;
    int          shown;

    assign pending = sorted_q.size();

    function automatic logic [31:0] abs_of(logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    // ascending signed order; saturated input can never reach the extreme
    task automatic sort_and_queue();
        logic [31:0] a[$];
        logic [31:0] t;
        int n;
        a = held;
        n = a.size();
        for (int i = 1; i < n; i++) begin
            t = a[i];
            for (int j = i - 1; j >= 0 && $signed(a[j]) > $signed(t); j--) begin
                a[j + 1] = a[j];
                a[j] = t;
            end
        end
        for (int i = 0; i < n; i++)
            sorted_q.push_back('{a[i], i == n - 1, dropped});
        held = {};
        dropped = 1'b0;
        sets_sorted++;
    endtask

    always @(posedge aclk) begin
        sorted_t got, want;
        logic [31:0] v;
        if (!aresetn) begin
            held = {};
            sorted_q = {};
            dropped = 1'b0;
            fail_count = 0;
            shown = 0;
            sets_sorted = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                v = (s_tdata == 32'h8000_0000) ? 32'h8000_0001 : s_tdata;
                if (held.size() < DEPTH) held.push_back(v);
                else dropped = 1'b1;
                if (s_tlast) sort_and_queue();
            end
            if (m_tvalid && m_tready) begin
                got = '{m_tdata, m_tlast, m_tuser};
                if (sorted_q.size() == 0) begin
                    fail_count++;
                    if (shown < 10) begin
                        shown++;
                        $display("unexpected result %h", got);
                    end
                end else begin
                    want = sorted_q.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (shown < 10) begin
                            shown++;
                            $display("mismatch: exp value=%0d last=%b trunc=%b,",
                                $signed(want.value), want.eos, want.trunc);
                            $display("          got value=%0d last=%b trunc=%b",
                                $signed(got.value), got.eos, got.trunc);
                        end
                    end
                end
            end
        end
    end

endmodule

FILE: dv/tb_radix_sort_decimal_lsd_core.sv
module tb_radix_sort_decimal_lsd_core;

    localparam int DEPTH = rsd_pkg::DEPTH_DEF;
    localparam int CYCLE_LIMIT = 1_000_000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    int fail_count, pending, sets_sorted;
    int cycles = 0;
    int send_idle_pct = 0;   // chance in a hundred that the sender skips a cycle
    int recv_stall_pct = 0;  // chance in a hundred that the receiver stalls
    int requests = 0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    radix_sort_decimal_lsd_core #(.DEPTH(DEPTH)) u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata),   // value
        .s_tlast(s_tlast),   // last_item
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata),   // sorted_value
        .m_tlast(m_tlast),   // end_of_set
        .m_tuser(m_tuser)    // truncated
    );

    radix_sort_checker #(.DEPTH(DEPTH)) u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser),
        .fail_count(fail_count), .pending(pending), .sets_sorted(sets_sorted)
    );

    // receiver: random stalls, drawn fresh each edge
    always @(posedge aclk)
        m_tready <= aresetn && ($urandom_range(99) >= recv_stall_pct);

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("Test completed with failures");
            $finish;
        end
    end

    // one request; idle gaps come before it, with valid low during each gap
    task automatic send(input logic [31:0] v, input logic lst);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tlast  <= lst;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        requests++;
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(5))
            0: return $urandom_range(9);
            1: return -$urandom_range(99);
            2: return 32'h7fff_ffff;
            3: return 32'h8000_0001;
            4: return $urandom_range(999_999);
            default: return $urandom;   // includes the most negative pattern now and then
        endcase
    endfunction

    task automatic send_set(input int n);
        for (int i = 0; i < n; i++) send(rand_value(), i == n - 1);
    endtask

    initial begin
        int len;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, zero, ties, single element, most negative saturation
        send(32'd0, 1'b1);
        send(32'h7fff_ffff, 1'b0);
        send(32'h8000_0000, 1'b0);
        send(32'h8000_0001, 1'b0);
        send(32'd0, 1'b0);
        send(32'hffff_ffff, 1'b0);
        send(32'd1, 1'b0);
        send(32'd10, 1'b0);
        send(-32'sd10, 1'b0);
        send(32'd10, 1'b0);
        send(32'h5555_5555, 1'b0);
        send(32'haaaa_aaaa, 1'b1);
        send(32'd7, 1'b0);
        send(32'd7, 1'b1);

        // store full: DEPTH+3 elements, the overflow ones dropped
        for (int i = 0; i < DEPTH + 3; i++) send($urandom, i == DEPTH + 2);
        // exactly full, no overflow
        for (int i = 0; i < DEPTH; i++) send(rand_value(), i == DEPTH - 1);

        // random sets across three idling phases
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct  = (ph == 0) ? 16 : (ph == 1) ? 65 : 0;
            recv_stall_pct = (ph == 0) ? 65 : (ph == 1) ? 16 : 0;
            for (int k = 0; k < 3; k++) begin
                len = ($urandom_range(7) == 0) ? $urandom_range(DEPTH - 8, DEPTH + 4)
                                               : $urandom_range(1, 12);
                send_set(len);
            end
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        while (pending != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);

        $display("sent %0d requests in %0d sets, incl. overflow, saturation and extremes",
            requests, sets_sorted);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: radix_sort_decimal_lsd_core.f
src/rsd_pkg.sv
src/rsd_ram.sv
src/radix_sort_decimal_lsd_core.sv
src/rsd_checker.sv
dv/radix_sort_checker.sv
dv/tb_radix_sort_decimal_lsd_core.sv
